// ===== design/s2x_pkg.sv =====
// Package for the Super 2xSaI pixel scaler.
// Pixel and window types, blend masks and register indexes; no dependencies.
`timescale 1ns / 1ps
package s2x_pkg;

    typedef logic [15:0] t_pix;
    typedef t_pix t_row [4];
    typedef t_row t_win [4];

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PIXEL_FORMAT = 2'd2
    } t_reg_idx;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd240;

    // half and quarter blend masks, index 0 = RGB565, 1 = RGB555
    localparam t_pix HALF_MASK [2] = '{16'hF7DE, 16'h7BDE};
    localparam t_pix HALF_LOW  [2] = '{16'h0821, 16'h0421};
    localparam t_pix QUAR_MASK [2] = '{16'hE79C, 16'h739C};
    localparam t_pix QUAR_LOW  [2] = '{16'h1863, 16'h0C63};

endpackage

// ===== design/s2x_in_if.sv =====
// Source pixel channel of the Super 2xSaI scaler.
// Depends on s2x_pkg.
`timescale 1ns / 1ps
interface s2x_in_if;
    import s2x_pkg::*;
    logic valid;
    logic ready;
    t_pix pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== design/s2x_out_if.sv =====
// Output block channel of the Super 2xSaI scaler.
// Depends on s2x_pkg.
`timescale 1ns / 1ps
interface s2x_out_if;
    import s2x_pkg::*;
    logic        valid;
    logic        ready;
    t_pix        top_left;
    t_pix        top_right;
    t_pix        bottom_left;
    t_pix        bottom_right;
    logic [9:0]  block_col;
    logic [11:0] block_row;
    logic        last;
    modport source (output valid, output top_left, output top_right, output bottom_left,
                    output bottom_right, output block_col, output block_row, output last,
                    input ready);
    modport sink   (input valid, input top_left, input top_right, input bottom_left,
                    input bottom_right, input block_col, input block_row, input last,
                    output ready);
endinterface

// ===== design/s2x_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module s2x_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/s2x_kernel.sv =====
// Super 2xSaI block kernel: picks the 4x4 neighborhood out of the window
// with edge clamp and forms one 2x2 output block. Depends on s2x_pkg.
`timescale 1ns / 1ps
module s2x_kernel (
    input  s2x_pkg::t_win i_win,
    input  logic          i_wr,      // 0: centre in window row 1, 1: row 2
    input  logic          i_wc,      // same for columns
    input  logic          i_fmt,
    output s2x_pkg::t_pix o_tl,
    output s2x_pkg::t_pix o_tr,
    output s2x_pkg::t_pix o_bl,
    output s2x_pkg::t_pix o_br
);
    import s2x_pkg::*;

    function automatic t_pix blend2(input t_pix a, input t_pix b, input logic f);
        logic [16:0] s;
        s = 17'((a & HALF_MASK[f]) >> 1) + 17'((b & HALF_MASK[f]) >> 1)
          + 17'(a & b & HALF_LOW[f]);
        return (a == b) ? a : s[15:0];
    endfunction

    function automatic t_pix blend4(input t_pix a, input t_pix b, input t_pix c,
                                    input t_pix d, input logic f);
        logic [17:0] hi;
        logic [17:0] lo;
        hi = 18'((a & QUAR_MASK[f]) >> 2) + 18'((b & QUAR_MASK[f]) >> 2)
           + 18'((c & QUAR_MASK[f]) >> 2) + 18'((d & QUAR_MASK[f]) >> 2);
        lo = 18'(a & QUAR_LOW[f]) + 18'(b & QUAR_LOW[f])
           + 18'(c & QUAR_LOW[f]) + 18'(d & QUAR_LOW[f]);
        lo = (lo >> 2) & 18'(QUAR_LOW[f]);
        return 16'(hi + lo);
    endfunction

    function automatic logic signed [3:0] vote(input t_pix a, input t_pix b,
                                               input t_pix c, input t_pix d);
        logic [1:0] na;
        logic [1:0] nb;
        logic signed [3:0] v;
        na = 2'd0;
        nb = 2'd0;
        v  = 4'sd0;
        if (a == c) na = na + 2'd1; else if (b == c) nb = nb + 2'd1;
        if (a == d) na = na + 2'd1; else if (b == d) nb = nb + 2'd1;
        if (na <= 2'd1) v = v + 4'sd1;
        if (nb <= 2'd1) v = v - 4'sd1;
        return v;
    endfunction

    t_win p;
    t_pix t0, t1, t2, t3, l0, l1, l2, l3, k0, k1, k2, k3, b0, b1, b2, b3;
    logic signed [3:0] v;

    // neighborhood with clamp at the right and bottom window edge
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                logic [2:0] rr;
                logic [2:0] cc;
                rr = 3'(i) + 3'(i_wr);
                cc = 3'(j) + 3'(i_wc);
                if (rr > 3'd3) rr = 3'd3;
                if (cc > 3'd3) cc = 3'd3;
                p[i][j] = i_win[rr[1:0]][cc[1:0]];
            end
        end
    end

    assign {t0, t1, t2, t3} = {p[0][0], p[0][1], p[0][2], p[0][3]};
    assign {l0, l1, l2, l3} = {p[1][0], p[1][1], p[1][2], p[1][3]};
    assign {k0, k1, k2, k3} = {p[2][0], p[2][1], p[2][2], p[2][3]};
    assign {b0, b1, b2, b3} = {p[3][0], p[3][1], p[3][2], p[3][3]};

    assign v = vote(l2, l1, k0, b1) + vote(l2, l1, l0, t1)
             + vote(l2, l1, b2, k3) + vote(l2, l1, t2, l3);

    // right column of the block
    always_comb begin
        if (k1 == l2 && l1 != k2) begin
            o_tr = k1;
            o_br = k1;
        end else if (l1 == k2 && k1 != l2) begin
            o_tr = l1;
            o_br = l1;
        end else if (l1 == k2 && k1 == l2) begin
            if (v > 4'sd0) o_tr = l2;
            else if (v < 4'sd0) o_tr = l1;
            else o_tr = blend2(l1, l2, i_fmt);
            o_br = o_tr;
        end else begin
            if (l2 == k2 && k2 == b1 && k1 != b2 && k2 != b0)
                o_br = blend4(k2, k2, k2, k1, i_fmt);
            else if (l1 == k1 && k1 == b2 && b1 != k2 && k1 != b3)
                o_br = blend4(k1, k1, k1, k2, i_fmt);
            else
                o_br = blend2(k1, k2, i_fmt);
            if (l2 == k2 && l2 == t1 && l1 != t2 && l2 != t0)
                o_tr = blend4(l2, l2, l2, l1, i_fmt);
            else if (l1 == k1 && l1 == t2 && t1 != l2 && l1 != t3)
                o_tr = blend4(l2, l1, l1, l1, i_fmt);
            else
                o_tr = blend2(l1, l2, i_fmt);
        end
    end

    // left column of the block
    always_comb begin
        if (l1 == k2 && k1 != l2 && l0 == l1 && l1 != b2) o_bl = blend2(k1, l1, i_fmt);
        else if (l1 == k0 && l2 == l1 && l0 != k1 && l1 != b0) o_bl = blend2(k1, l1, i_fmt);
        else o_bl = k1;
        if (k1 == l2 && l1 != k2 && k0 == k1 && k1 != t2) o_tl = blend2(k1, l1, i_fmt);
        else if (l0 == k1 && k2 == k1 && k0 != l1 && k1 != t0) o_tl = blend2(k1, l1, i_fmt);
        else o_tl = l1;
    end
endmodule

// ===== design/super_2xsai_pixel_scaler_unit.sv =====
// Super 2xSaI pixel scaler, top level. Depends on s2x_pkg, s2x_in_if, s2x_out_if,
// s2x_ram and s2x_kernel.
//
// Takes one source pixel per clock in raster order, unless a pending block job
// or the output holds the input, and emits 2x2 output blocks tagged with the
// source column and row of their centre pixel. A pixel at the right or bottom
// edge can complete up to four blocks; it holds the input until the block
// emitter, which forms one block per cycle while the output is not stalled, has
// formed them all. The three previous lines live in one line RAM (one read at
// accept, write-back when the pixel leaves stage 1). The line RAM holds no reset
// state.
`timescale 1ns / 1ps
module super_2xsai_pixel_scaler_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    s2x_in_if.sink      i_pix,
    s2x_out_if.source   o_blk
);
    import s2x_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);

    // configuration and position
    logic [10:0]   r_fw;
    logic [11:0]   r_fh;
    logic          r_fmt;
    logic [XW-1:0] r_x;
    logic [11:0]   r_y;
    logic [XW-1:0] w_m1;
    logic [11:0]   h_m1;

    // stage 1: pixel waiting for its line RAM data
    logic          r_s1_v;
    t_pix          r_s1_pix;
    logic [XW-1:0] r_s1_x;
    logic          r_s1_ca, r_s1_cb, r_s1_ra, r_s1_rb;
    logic [XW-1:0] r_s1_c0, r_s1_c1;
    logic [11:0]   r_s1_r0, r_s1_r1;
    logic [47:0]   st;

    // window and block job list
    t_win          r_win;
    logic          r_jv;
    logic [XW-1:0] r_jc [2];
    logic          r_jwc [2];
    logic          r_jnc;
    logic [11:0]   r_jr [2];
    logic          r_jwr [2];
    logic          r_jnr;
    logic          r_ci, r_ri;

    // output register
    logic          r_ov;
    t_pix          r_tl, r_tr, r_bl, r_br;
    logic [9:0]    r_col;
    logic [11:0]   r_row;
    logic          r_last;

    logic accept, s1_adv, emit, job_last, job_done;
    t_pix k_tl, k_tr, k_bl, k_br;

    // effective geometry, minus one
    always_comb begin
        if (r_fw < 11'd3) w_m1 = XW'(2);
        else if (32'(r_fw) > 32'(MAX_WIDTH)) w_m1 = XW'(MAX_WIDTH - 1);
        else w_m1 = XW'(r_fw - 11'd1);
        h_m1 = (r_fh < 12'd3) ? 12'd2 : (r_fh - 12'd1);
    end

    // handshake
    assign job_last = (r_ri == r_jnr) && (r_ci == r_jnc);
    assign emit     = r_jv && (!r_ov || o_blk.ready);
    assign job_done = emit && job_last;
    assign s1_adv   = r_s1_v && (!r_jv || job_done);
    assign i_pix.ready = !r_s1_v || s1_adv;
    assign accept   = i_pix.valid && i_pix.ready;

    s2x_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_x),
        .i_wdata ({st[31:0], r_s1_pix}),
        .i_re    (accept),
        .i_raddr (r_x),
        .o_rdata (st)
    );

    s2x_kernel u_kernel (
        .i_win (r_win),
        .i_wr  (r_jwr[r_ri]),
        .i_wc  (r_jwc[r_ci]),
        .i_fmt (r_fmt),
        .o_tl  (k_tl),
        .o_tr  (k_tr),
        .o_bl  (k_bl),
        .o_br  (k_br)
    );

    // configuration, position counters and stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= RST_FRAME_WIDTH[10:0];
            r_fh   <= RST_FRAME_HEIGHT;
            r_fmt  <= 1'b0;
            r_x    <= '0;
            r_y    <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_pix <= i_pix.pixel;
                r_s1_x   <= r_x;
                r_s1_ca  <= (32'(r_x) >= 32'd3);
                r_s1_cb  <= (r_x == w_m1);
                r_s1_ra  <= (r_y >= 12'd3);
                r_s1_rb  <= (r_y == h_m1);
                r_s1_c0  <= r_x - XW'(2);
                r_s1_c1  <= w_m1 - XW'(1);
                r_s1_r0  <= r_y - 12'd2;
                r_s1_r1  <= h_m1 - 12'd1;
                if (r_x == w_m1) begin
                    r_x <= '0;
                    r_y <= (r_y == h_m1) ? 12'd0 : (r_y + 12'd1);
                end else begin
                    r_x <= r_x + XW'(1);
                end
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH: begin
                        r_fw <= i_cfg_data[10:0];
                        r_x  <= '0;
                        r_y  <= '0;
                    end
                    REG_FRAME_HEIGHT: begin
                        r_fh <= i_cfg_data;
                        r_x  <= '0;
                        r_y  <= '0;
                    end
                    REG_PIXEL_FORMAT: r_fmt <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // window shift and job list load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_win[i][j] <= '0;
                end
            end
            r_jv <= 1'b0;
            r_ci <= 1'b0;
            r_ri <= 1'b0;
        end else begin
            if (s1_adv) begin
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                end
                r_win[0][3] <= st[47:32];
                r_win[1][3] <= st[31:16];
                r_win[2][3] <= st[15:0];
                r_win[3][3] <= r_s1_pix;
                r_jv   <= (r_s1_ca || r_s1_cb) && (r_s1_ra || r_s1_rb);
                r_ci   <= 1'b0;
                r_ri   <= 1'b0;
                r_jc[0]  <= r_s1_ca ? r_s1_c0 : r_s1_c1;
                r_jwc[0] <= !r_s1_ca;
                r_jc[1]  <= r_s1_c1;
                r_jwc[1] <= 1'b1;
                r_jnc    <= r_s1_ca && r_s1_cb;
                r_jr[0]  <= r_s1_ra ? r_s1_r0 : r_s1_r1;
                r_jwr[0] <= !r_s1_ra;
                r_jr[1]  <= r_s1_r1;
                r_jwr[1] <= 1'b1;
                r_jnr    <= r_s1_ra && r_s1_rb;
            end else begin
                // step through the job list, columns within each row, then the next row
                if (emit) begin
                    if (r_ci == r_jnc) begin
                        r_ci <= 1'b0;
                        r_ri <= r_ri + 1'b1;
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                if (job_done) begin
                    r_jv <= 1'b0;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (emit) begin
                r_ov   <= 1'b1;
                r_tl   <= k_tl;
                r_tr   <= k_tr;
                r_bl   <= k_bl;
                r_br   <= k_br;
                r_col  <= 10'(r_jc[r_ci]);
                r_row  <= r_jr[r_ri];
                r_last <= job_last;
            end else if (o_blk.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_blk.valid        = r_ov;
    assign o_blk.top_left     = r_tl;
    assign o_blk.top_right    = r_tr;
    assign o_blk.bottom_left  = r_bl;
    assign o_blk.bottom_right = r_br;
    assign o_blk.block_col    = r_col;
    assign o_blk.block_row    = r_row;
    assign o_blk.last         = r_last;
endmodule
